@@ src/llacs_pkg.sv @@
// ----------------------------------------------------------------------------
// llacs_pkg
// Shared types and constants of the life-like cell step block: pixel and
// field widths, command kinds, configuration register indexes and the
// control group that drives the per-bit neighbour counters.
// ----------------------------------------------------------------------------
package llacs_pkg;

    // Field widths of the channels.
    localparam int POS_W     = 6;
    localparam int COORD_W   = 7;
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 18;
    localparam int RULE_W    = 18;

    // Neighbour count runs from 0 to 8; survival rules sit nine bits up.
    localparam int CNT_W              = 4;
    localparam int RULE_IDX_W         = 5;
    localparam int RULE_SURVIVE_SHIFT = 9;
    localparam int NEIGHBOURS         = 8;

    // Command kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_MASK  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] FRAME_ROWS_RST = 7'd64;
    localparam logic [COORD_W-1:0] FRAME_COLS_RST = 7'd64;
    localparam logic [RULE_W-1:0]  RULE_MASK_RST  = 18'h01808;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [CNT_W-1:0]   count_t;

    // Control of the neighbour counter lanes.
    typedef struct packed {
        logic clear;     // any accepted command beat; starts a new evaluation
        logic load_self; // read data holds the centre cell
        logic add_nbr;   // read data holds one neighbour
    } lane_ctl_t;

endpackage

@@ src/llacs_cmd_if.sv @@
// ----------------------------------------------------------------------------
// llacs_cmd_if
// Command channel: pixel writes and cell evaluations, one per beat.
// ----------------------------------------------------------------------------
interface llacs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [llacs_pkg::POS_W-1:0]  row;
    logic [llacs_pkg::POS_W-1:0]  col;
    logic [llacs_pkg::CHAN_W-1:0] red_in;
    logic [llacs_pkg::CHAN_W-1:0] green_in;
    logic [llacs_pkg::CHAN_W-1:0] blue_in;

    modport source (output valid, kind, row, col, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, kind, row, col, red_in, green_in, blue_in,
                    output ready);
endinterface

@@ src/llacs_res_if.sv @@
// ----------------------------------------------------------------------------
// llacs_res_if
// Result channel: one next-generation pixel per evaluation beat.
// ----------------------------------------------------------------------------
interface llacs_res_if;
    logic                         valid;
    logic                         ready;
    logic [llacs_pkg::CHAN_W-1:0] red_next;
    logic [llacs_pkg::CHAN_W-1:0] green_next;
    logic [llacs_pkg::CHAN_W-1:0] blue_next;
    logic                         bad_position;

    modport source (output valid, red_next, green_next, blue_next, bad_position,
                    input ready);
    modport sink   (input valid, red_next, green_next, blue_next, bad_position,
                    output ready);
endinterface

@@ src/llacs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// llacs_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface llacs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [llacs_pkg::CFG_IDX_W-1:0]  index;
    logic [llacs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/life_like_automaton_cell_step.sv @@
// ----------------------------------------------------------------------------
// life_like_automaton_cell_step
// Toroidal frame of 24-bit pixels held in one single-port memory. Write
// beats store a pixel; evaluate beats read the cell and its eight wrapped
// neighbours and apply a life-like rule to each of the 24 bit-planes.
// ----------------------------------------------------------------------------
// Flow: a write beat is stored at its accepting edge; an evaluate beat goes
// through the issue cycle, the READ steps that stream the nine words through
// the single memory port, and DONE, which loads the result register once it is
// free or taken. An out-of-frame beat skips READ. One write per cycle while
// idle; no new beat is taken until an evaluation has loaded its result.
// Reset restores the frame size and rule registers and empties the output
// register; the frame memory is not cleared and holds nothing until written.
// ----------------------------------------------------------------------------
module life_like_automaton_cell_step #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input logic        clk,
    input logic        rst_n,
    llacs_cmd_if.sink   cmd,
    llacs_res_if.source res,
    llacs_cfg_if.sink   cfg
);
    import llacs_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = $clog2(DEPTH);
    localparam int ROW_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COL_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [3:0] STEP_SELF  = 4'd0;
    localparam logic [3:0] STEP_FIRST = 4'd1;
    localparam logic [3:0] STEP_LAST  = 4'd9;

    // Configuration registers.
    logic [COORD_W-1:0] rows_reg;
    logic [COORD_W-1:0] cols_reg;
    logic [RULE_W-1:0]  rule_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= FRAME_ROWS_RST;
            cols_reg <= FRAME_COLS_RST;
            rule_reg <= RULE_MASK_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FRAME_ROWS: rows_reg <= cfg.data[COORD_W-1:0];
                CFG_FRAME_COLS: cols_reg <= cfg.data[COORD_W-1:0];
                CFG_RULE_MASK:  rule_reg <= cfg.data[RULE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Effective frame size and position check of the incoming beat.
    logic [COORD_W-1:0] nr;
    logic [COORD_W-1:0] nc;
    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;
    logic               in_bad;

    assign nr     = (rows_reg > COORD_W'(ROW_CAP)) ? COORD_W'(ROW_CAP) : rows_reg;
    assign nc     = (cols_reg > COORD_W'(COL_CAP)) ? COORD_W'(COL_CAP) : cols_reg;
    assign in_row = {1'b0, cmd.row};
    assign in_col = {1'b0, cmd.col};
    assign in_bad = (in_row >= nr) || (in_col >= nc);

    // Control state.
    logic [1:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       cmd_fire;
    logic       load_out;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                step_next = STEP_SELF;
                if (cmd_fire && cmd.kind == KIND_EVAL)
                begin
                    state_next = in_bad ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_SELF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Cell and wrapped neighbour coordinates, captured on every accepted beat.
    logic [COORD_W-1:0] row_reg, col_reg;
    logic [COORD_W-1:0] up_reg, dn_reg, lf_reg, rt_reg;
    logic               bad_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            up_reg  <= (in_row == '0) ? nr - 7'd1 : in_row - 7'd1;
            dn_reg  <= (in_row + 7'd1 == nr) ? '0 : in_row + 7'd1;
            lf_reg  <= (in_col == '0) ? nc - 7'd1 : in_col - 7'd1;
            rt_reg  <= (in_col + 7'd1 == nc) ? '0 : in_col + 7'd1;
            bad_reg <= in_bad;
        end
    end

    // Read location for each step: the centre first, then the eight neighbours.
    logic [COORD_W-1:0] sel_row, sel_col;

    always_comb
    begin
        case (step_reg)
            4'd1:    begin sel_row = up_reg;  sel_col = lf_reg;  end
            4'd2:    begin sel_row = up_reg;  sel_col = col_reg; end
            4'd3:    begin sel_row = up_reg;  sel_col = rt_reg;  end
            4'd4:    begin sel_row = row_reg; sel_col = lf_reg;  end
            4'd5:    begin sel_row = row_reg; sel_col = rt_reg;  end
            4'd6:    begin sel_row = dn_reg;  sel_col = lf_reg;  end
            4'd7:    begin sel_row = dn_reg;  sel_col = col_reg; end
            4'd8:    begin sel_row = dn_reg;  sel_col = rt_reg;  end
            default: begin sel_row = row_reg; sel_col = col_reg; end
        endcase
    end

    // Single-port frame memory: writes from the command beat, reads in READ.
    pixel_t          frame_mem [DEPTH];
    pixel_t          rd_data_reg;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    pixel_t          mem_wdata;

    assign mem_we    = cmd_fire && (cmd.kind == KIND_WRITE) && !in_bad;
    assign mem_wdata = {cmd.red_in, cmd.green_in, cmd.blue_in};
    assign mem_addr  = (state_reg == ST_IDLE)
                     ? AW'(32'(in_row) * MAX_COLS + 32'(in_col))
                     : AW'(32'(sel_row) * MAX_COLS + 32'(sel_col));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[mem_addr];
    end

    // Lane control: the memory read is registered, so read data trails the address.
    lane_ctl_t lane_ctl;
    pixel_t    pixel_next;

    assign lane_ctl.clear     = cmd_fire;
    assign lane_ctl.load_self = (state_reg == ST_READ) && (step_reg == STEP_FIRST);
    assign lane_ctl.add_nbr   = (state_reg == ST_READ) && (step_reg > STEP_FIRST);

    llacs_lane_count u_lanes (
        .clk        (clk),
        .ctl        (lane_ctl),
        .rd_data    (rd_data_reg),
        .rule_mask  (rule_reg),
        .pixel_next (pixel_next)
    );

    // Output register.
    pixel_t out_px_reg;
    logic   out_bad_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_px_reg  <= bad_reg ? '0 : pixel_next;
            out_bad_reg <= bad_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.red_next     = out_px_reg[23:16];
    assign res.green_next   = out_px_reg[15:8];
    assign res.blue_next    = out_px_reg[7:0];
    assign res.bad_position = out_bad_reg;

    // Checks.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.bad_position) |->
            (res.red_next == '0 && res.green_next == '0 && res.blue_next == '0))
        else $error("out-of-frame result carries a colour");

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && step_reg == STEP_LAST) |=> (state_reg == ST_DONE))
        else $error("read sequence did not finish after nine words");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("frame write while an evaluation owns the port");

    a_eval_bad_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.kind == KIND_EVAL && in_bad) |=> (state_reg == ST_DONE))
        else $error("out-of-frame evaluation went through the read sequence");

endmodule

@@ src/llacs_lane_count.sv @@
// ----------------------------------------------------------------------------
// llacs_lane_count
// Twenty-four bit-plane lanes. Each lane keeps its centre bit and counts
// the set neighbour bits as frame words stream in, then looks up the
// birth or survival rule to give the next-generation bit.
// ----------------------------------------------------------------------------
module llacs_lane_count (
    input  logic                                clk,
    input  llacs_pkg::lane_ctl_t                ctl,
    input  llacs_pkg::pixel_t                   rd_data,
    input  logic [llacs_pkg::RULE_W-1:0]        rule_mask,
    output llacs_pkg::pixel_t                   pixel_next
);
    import llacs_pkg::*;

    count_t cnt_reg [PIXEL_W];
    pixel_t self_reg;

    // Per-lane accumulation of neighbour bits.
    always_ff @(posedge clk)
    begin
        if (ctl.load_self)
        begin
            self_reg <= rd_data;
        end
        for (int b = 0; b < PIXEL_W; b++)
        begin
            if (ctl.clear)
            begin
                cnt_reg[b] <= '0;
            end
            else if (ctl.add_nbr)
            begin
                cnt_reg[b] <= cnt_reg[b] + count_t'(rd_data[b]);
            end
        end
    end

    // Rule lookup: survival entries sit above the birth entries.
    always_comb
    begin
        logic [RULE_IDX_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < PIXEL_W; b++)
        begin
            idx = RULE_IDX_W'(cnt_reg[b])
                + (self_reg[b] ? RULE_IDX_W'(RULE_SURVIVE_SHIFT) : '0);
            pixel_next[b] = rule_mask[idx];
        end
    end

endmodule
